// File: rtl/core/fpa_pkg.sv
// Shared constants for the fit partition allocator: field widths,
// operation codes, policy codes and configuration register indexes.
// No dependencies.
package fpa_pkg;

  localparam int SLOT_W      = 4;
  localparam int AMOUNT_W    = 16;
  localparam int INDEX_W     = 4;
  localparam int REMAIN_W    = 16;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int ACTIVE_W    = 5;

  localparam int BLOCKS_DEF    = 16;
  localparam int SIZE_BITS_DEF = 16;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;
  // unused code, searched as first fit
  localparam logic [1:0] POLICY_SPARE = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_SHARED = 2'd1;
  localparam logic [1:0] REG_ACTIVE = 2'd2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

endpackage

// File: rtl/core/fpa_chan_if.sv
// Valid/ready channel interfaces for the allocator's request and result beats.
// Depends on fpa_pkg for field widths.
interface fpa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [fpa_pkg::SLOT_W-1:0]    slot;
  logic [fpa_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, opcode, slot, amount, input ready);
  modport sink   (input valid, opcode, slot, amount, output ready);
endinterface

interface fpa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [fpa_pkg::INDEX_W-1:0]   block_index;
  logic [fpa_pkg::REMAIN_W-1:0]  remaining;

  modport source (output valid, found, block_index, remaining, input ready);
  modport sink   (input valid, found, block_index, remaining, output ready);
endinterface

// File: rtl/core/fit_partition_allocator_unit.sv
// Fixed-partition allocator: size table in a synchronous RAM, scanned per request.
// Depends on fpa_pkg and the channel interfaces in fpa_chan_if.sv.
//
// Usage:
//   in_chan  carries load beats (opcode 0: write amount into slot, clear its
//            occupied mark; no result) and request beats (opcode 1).
//   out_chan returns one beat per request: found, block_index, remaining.
//   APB port: reg 0 fit policy (0x0), reg 1 shared mode (0x4),
//            reg 2 active block count (0x8). pready is tied high.
// Sequencing:
//   A load is written to the size table as it is accepted. A request
//   scans N = min(active_blocks, BLOCKS) entries (none when N is zero):
//   the size RAM has one read port and is scanned one entry per cycle
//   through the read data register, then the done state writes back
//   the chosen block (shrunk size or occupied mark) and loads the
//   result. The next beat is taken once the block is idle again, even
//   if the result has not been taken yet.
// Reset clears the occupied marks and resets the config registers; the size
//   table is undefined until loaded. While the result register is full and the
//   receiver stalls, a finished request waits before its write-back.
module fit_partition_allocator_unit #(
  parameter int BLOCKS    = fpa_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fpa_in_if.sink                          in_chan,
  fpa_out_if.source                       out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fpa_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fpa_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW = $clog2(BLOCKS + 1);
  localparam int W  = (SIZE_BITS > fpa_pkg::AMOUNT_W) ? SIZE_BITS : fpa_pkg::AMOUNT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                         state_r;
  logic [1:0]                     policy_r;
  logic                           shared_r;
  logic [fpa_pkg::ACTIVE_W-1:0]   active_r;

  logic [SIZE_BITS-1:0]           mem [BLOCKS];
  logic [SIZE_BITS-1:0]           rd_data_r;
  logic                           mem_we;
  logic [IW-1:0]                  mem_waddr;
  logic [SIZE_BITS-1:0]           mem_wdata;

  logic [BLOCKS-1:0]              occ_r;
  logic [fpa_pkg::AMOUNT_W-1:0]   amt_r;
  logic [CW-1:0]                  count_r;
  logic [CW-1:0]                  rd_idx_r;
  logic                           cmp_v_r;
  logic [IW-1:0]                  cmp_idx_r;
  logic                           have_r;
  logic [IW-1:0]                  pick_r;
  logic [W-1:0]                   left_r;

  logic                           out_valid_r;
  logic                           out_found_r;
  logic [fpa_pkg::INDEX_W-1:0]    out_index_r;
  logic [fpa_pkg::REMAIN_W-1:0]   out_remain_r;

  logic                           in_fire;
  logic                           slot_ok;
  logic                           cfg_we;
  logic [CW-1:0]                  cnt;
  logic                           issue;
  logic                           last;
  logic [W-1:0]                   size_x;
  logic [W-1:0]                   amt_x;
  logic [W-1:0]                   left;
  logic                           take;
  logic                           done_fire;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpa_pkg::POLICY_FIRST;
      shared_r <= 1'b0;
      active_r <= fpa_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        fpa_pkg::REG_POLICY: policy_r <= pwdata[1:0];
        fpa_pkg::REG_SHARED: shared_r <= pwdata[0];
        fpa_pkg::REG_ACTIVE: active_r <= pwdata[fpa_pkg::ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fpa_pkg::REG_POLICY: prdata = fpa_pkg::CFG_DATA_W'(policy_r);
      fpa_pkg::REG_SHARED: prdata = fpa_pkg::CFG_DATA_W'(shared_r);
      fpa_pkg::REG_ACTIVE: prdata = fpa_pkg::CFG_DATA_W'(active_r);
      default:             prdata = '0;
    endcase
  end

  // handshake and scan control
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign slot_ok       = (32'(in_chan.slot) < 32'(BLOCKS));
  assign cnt           = (32'(active_r) > 32'(BLOCKS)) ? CW'(BLOCKS) : CW'(active_r);
  assign issue         = (rd_idx_r < count_r);
  assign last          = (CW'(cmp_idx_r) == (count_r - CW'(1)));
  assign done_fire     = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    size_x = W'(rd_data_r);
    amt_x  = W'(amt_r);
    left   = size_x - amt_x;
    take   = cmp_v_r && (size_x >= amt_x) && (shared_r || !occ_r[cmp_idx_r]) &&
             (!have_r ||
              (policy_r == fpa_pkg::POLICY_BEST  && left < left_r) ||
              (policy_r == fpa_pkg::POLICY_WORST && left > left_r));
  end

  // size table
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pick_r;
    mem_wdata = SIZE_BITS'(left_r);
    if (in_fire && in_chan.opcode == fpa_pkg::OP_LOAD && slot_ok) begin
      mem_we    = 1'b1;
      mem_waddr = IW'(in_chan.slot);
      mem_wdata = SIZE_BITS'(in_chan.amount);
    end else if (done_fire && have_r && shared_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_idx_r[IW-1:0]];
  end

  // state machine, occupied marks and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      cmp_v_r     <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      count_r     <= '0;
    end else begin
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          cmp_v_r <= 1'b0;
          if (in_fire) begin
            if (in_chan.opcode == fpa_pkg::OP_LOAD) begin
              if (slot_ok) begin
                occ_r[IW'(in_chan.slot)] <= 1'b0;
              end
            end else begin
              amt_r    <= in_chan.amount;
              rd_idx_r <= '0;
              count_r  <= cnt;
              have_r   <= 1'b0;
              pick_r   <= '0;
              left_r   <= '0;
              state_r  <= (cnt == '0) ? ST_DONE : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_idx_r <= rd_idx_r + CW'(1);
          end
          cmp_v_r   <= issue;
          cmp_idx_r <= rd_idx_r[IW-1:0];
          if (take) begin
            have_r <= 1'b1;
            pick_r <= cmp_idx_r;
            left_r <= left;
          end
          if (cmp_v_r && last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          cmp_v_r <= 1'b0;
          if (done_fire) begin
            out_found_r  <= have_r;
            out_index_r  <= fpa_pkg::INDEX_W'(pick_r);
            out_remain_r <= fpa_pkg::REMAIN_W'(left_r);
            if (have_r && !shared_r) begin
              occ_r[pick_r] <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.block_index = out_index_r;
  assign out_chan.remaining   = out_remain_r;

  // checks
  a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.opcode == fpa_pkg::OP_REQUEST |=> state_r != ST_IDLE)
    else $error("request did not start a scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> rd_idx_r <= count_r)
    else $error("scan index ran past active count");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && have_r |-> CW'(pick_r) < count_r)
    else $error("chosen block outside active range");

  a_pick_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && have_r && !shared_r |-> !occ_r[pick_r])
    else $error("exclusive mode chose an occupied block");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire && !have_r |=> out_valid_r && out_index_r == '0 && out_remain_r == '0)
    else $error("miss result not zeroed");

endmodule

// File: verif/tb_fit_partition_allocator_unit.sv
// Testbench for fit_partition_allocator_unit: load and request beats checked against
// an in-bench allocation predictor under all fit policies, both sharing modes, many sizes.
// Depends on fpa_pkg, fpa_chan_if.sv and the allocator RTL.
module tb_fit_partition_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                         found;
    logic [fpa_pkg::INDEX_W-1:0]  block_index;
    logic [fpa_pkg::REMAIN_W-1:0] remaining;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [fpa_pkg::CFG_ADDR_W-1:0] paddr;
  logic [fpa_pkg::CFG_DATA_W-1:0] pwdata, prdata;

  fpa_in_if  in_if();
  fpa_out_if out_if();

  fit_partition_allocator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // allocator mirror
  logic [1:0]                   cfg_policy;
  logic                         cfg_shared;
  logic [fpa_pkg::ACTIVE_W-1:0] cfg_active;
  logic [fpa_pkg::AMOUNT_W-1:0] part_size [fpa_pkg::BLOCKS_DEF];
  logic                         part_taken [fpa_pkg::BLOCKS_DEF];
  alloc_result_t                pending_allocs [$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  gaps_on = 1'b1;
  int  burst_left = 0;
  bit  hold_ask = 1'b0;

  function automatic alloc_result_t allocate_partition(logic [fpa_pkg::AMOUNT_W-1:0] amt);
    alloc_result_t r;
    int span;
    bit have;
    int pick;
    logic [fpa_pkg::AMOUNT_W-1:0] left, pick_left;
    have = 1'b0;
    pick = 0;
    pick_left = '0;
    span = (cfg_active > fpa_pkg::BLOCKS_DEF) ? fpa_pkg::BLOCKS_DEF : int'(cfg_active);
    for (int j = 0; j < span; j++) begin
      if (part_size[j] < amt) continue;
      if (!cfg_shared && part_taken[j]) continue;
      left = part_size[j] - amt;
      if (!have) begin
        have = 1'b1;
        pick = j;
        pick_left = left;
        if (cfg_policy != fpa_pkg::POLICY_BEST && cfg_policy != fpa_pkg::POLICY_WORST) break;
      end else if (cfg_policy == fpa_pkg::POLICY_BEST && left < pick_left) begin
        pick = j;
        pick_left = left;
      end else if (cfg_policy == fpa_pkg::POLICY_WORST && left > pick_left) begin
        pick = j;
        pick_left = left;
      end
    end
    if (!have) begin
      r = '0;
    end else begin
      if (cfg_shared) part_size[pick] = pick_left;
      else part_taken[pick] = 1'b1;
      r.found = 1'b1;
      r.block_index = pick[fpa_pkg::INDEX_W-1:0];
      r.remaining = pick_left;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch %s: expected %0h actual %0h", $realtime, what, want, got);
  endtask

  // sampling at the rising edge: results checked, accepted beats predicted
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n === 1'b1) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_allocs.size() == 0) begin
          note_mismatch("unexpected result", 0, {out_if.found, out_if.block_index,
                        out_if.remaining});
        end else begin
          want = pending_allocs.pop_front();
          if (out_if.found !== want.found)
            note_mismatch("found", want.found, out_if.found);
          if (out_if.block_index !== want.block_index)
            note_mismatch("block_index", want.block_index, out_if.block_index);
          if (out_if.remaining !== want.remaining)
            note_mismatch("remaining", want.remaining, out_if.remaining);
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.opcode == fpa_pkg::OP_LOAD) begin
          part_size[in_if.slot] = in_if.amount;
          part_taken[in_if.slot] = 1'b0;
        end else begin
          pending_allocs.push_back(allocate_partition(in_if.amount));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("** fit_partition_allocator_unit: FAILED **");
        $finish;
      end
    end
  end

  // result receiver: shifting stall patterns plus one long hold-off on request
  initial begin
    int cyc;
    int mode;
    int hold_left;
    bit held;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= (cyc % 4) != 0;
          2: out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= (cyc % 16) < 3;
        endcase
      end
      cyc++;
    end
  end

  task automatic send_beat(input logic op, input logic [fpa_pkg::SLOT_W-1:0] s,
                           input logic [fpa_pkg::AMOUNT_W-1:0] amt);
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.slot <= s;
    in_if.amount <= amt;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle;
    in_if.valid <= 1'b0;
    while (pending_allocs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [fpa_pkg::CFG_DATA_W-1:0] value);
    logic [fpa_pkg::CFG_DATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      fpa_pkg::REG_POLICY: cfg_policy = value[1:0];
      fpa_pkg::REG_SHARED: cfg_shared = value[0];
      fpa_pkg::REG_ACTIVE: cfg_active = value[fpa_pkg::ACTIVE_W-1:0];
      default: ;
    endcase
    if (rd !== value) note_mismatch($sformatf("readback reg %0d", idx), value, rd);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] pol, input logic sh,
                            input logic [fpa_pkg::ACTIVE_W-1:0] act);
    write_reg(fpa_pkg::REG_POLICY, fpa_pkg::CFG_DATA_W'(pol));
    write_reg(fpa_pkg::REG_SHARED, fpa_pkg::CFG_DATA_W'(sh));
    write_reg(fpa_pkg::REG_ACTIVE, fpa_pkg::CFG_DATA_W'(act));
  endtask

  task automatic send_random_items(input int count);
    logic op;
    logic [fpa_pkg::AMOUNT_W-1:0] amt;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < 35) ? fpa_pkg::OP_LOAD : fpa_pkg::OP_REQUEST;
      amt = ($urandom_range(0, 4) == 0) ? fpa_pkg::AMOUNT_W'($urandom_range(0, 65535))
                                        : fpa_pkg::AMOUNT_W'($urandom_range(0, 255));
      send_beat(op, fpa_pkg::SLOT_W'($urandom_range(0, 15)), amt);
    end
  endtask

  // every slot loaded before any search, then exact fits, zero and full-size requests
  task automatic test_directed;
    logic [fpa_pkg::AMOUNT_W-1:0] sizes [fpa_pkg::BLOCKS_DEF];
    sizes = '{16'h0000, 16'hFFFF, 16'd100, 16'd100, 16'd50, 16'hAAAA, 16'h5555, 16'd200,
              16'd210, 16'd220, 16'd230, 16'd240, 16'd250, 16'd260, 16'd270, 16'd280};
    set_config(fpa_pkg::POLICY_FIRST, 1'b0, fpa_pkg::ACTIVE_RESET);
    for (int i = 0; i < fpa_pkg::BLOCKS_DEF; i++)
      send_beat(fpa_pkg::OP_LOAD, fpa_pkg::SLOT_W'(i), sizes[i]);
    send_beat(fpa_pkg::OP_REQUEST, 4'hF, 16'hFFFF);
    send_beat(fpa_pkg::OP_REQUEST, 4'h0, 16'h0000);
    send_beat(fpa_pkg::OP_REQUEST, 4'h0, 16'd100);
    send_beat(fpa_pkg::OP_REQUEST, 4'h0, 16'd100);
    send_beat(fpa_pkg::OP_REQUEST, 4'h0, 16'd100);
    send_beat(fpa_pkg::OP_REQUEST, 4'h0, 16'hFFFF);
    send_beat(fpa_pkg::OP_REQUEST, 4'h0, 16'h5555);
    wait_idle();
  endtask

  task automatic test_policies;
    logic [fpa_pkg::ACTIVE_W-1:0] act_list [8];
    logic [1:0] pol_list [4];
    int phase;
    act_list = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd12, 5'd2};
    pol_list = '{fpa_pkg::POLICY_FIRST, fpa_pkg::POLICY_BEST, fpa_pkg::POLICY_WORST,
                 fpa_pkg::POLICY_SPARE};
    phase = 0;
    for (int p = 0; p < 4; p++) begin
      for (int sh = 0; sh < 2; sh++) begin
        set_config(pol_list[p], sh[0], act_list[phase % 8]);
        gaps_on = (phase % 3) != 2;
        send_random_items(52);
        wait_idle();
        phase++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // results held back long enough that the block stops taking beats
  task automatic test_backpressure;
    set_config(fpa_pkg::POLICY_BEST, 1'b1, fpa_pkg::ACTIVE_RESET);
    gaps_on = 1'b0;
    hold_ask = 1'b1;
    for (int i = 0; i < 20; i++)
      send_beat(fpa_pkg::OP_REQUEST, fpa_pkg::SLOT_W'($urandom_range(0, 15)),
                fpa_pkg::AMOUNT_W'($urandom_range(0, 63)));
    gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = fpa_pkg::OP_LOAD;
    in_if.slot = '0;
    in_if.amount = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_policy = fpa_pkg::POLICY_FIRST;
    cfg_shared = 1'b0;
    cfg_active = fpa_pkg::ACTIVE_RESET;
    for (int i = 0; i < fpa_pkg::BLOCKS_DEF; i++) begin
      part_size[i] = '0;
      part_taken[i] = 1'b0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_policies();
    test_backpressure();

    wait_idle();
    if (mismatches == 0 && pending_allocs.size() == 0) begin
      $display("** fit_partition_allocator_unit: PASSED **");
    end else begin
      $display("** fit_partition_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
